/* design/ipat_pkg.sv */
package ipat_pkg;

  localparam int unsigned CapW  = 7;
  localparam int unsigned CharW = 7;
  localparam int unsigned LenW  = 6;

  localparam logic [CapW-1:0] CapReset = 7'd64;

  localparam logic [1:0] FamIpv4 = 2'd0;
  localparam logic [1:0] FamIpv6 = 2'd1;

  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChLowA  = 7'h61;
  localparam logic [CharW-1:0] ChColon = 7'h3a;
  localparam logic [CharW-1:0] ChDot   = 7'h2e;
  localparam logic [CharW-1:0] ChNull  = 7'h00;

  typedef enum logic [2:0] {
    StIdle,
    StZrun,
    StScan,
    StCheck,
    StEmit
  } state_e;

  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } dec_t;

  // Lower-case hex digit.
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] d);
    logic [CharW-1:0] c;
    if (d < 4'd10) begin
      c = ChZero + {3'b000, d};
    end else begin
      c = ChLowA + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

  // Split a byte into decimal digits by compare and subtract.
  function automatic dec_t byte_to_dec(input logic [7:0] v);
    dec_t       r;
    logic [7:0] rem;
    logic [7:0] t8;
    if (v >= 8'd200) begin
      r.hund = 2'd2;
      rem    = v - 8'd200;
    end else if (v >= 8'd100) begin
      r.hund = 2'd1;
      rem    = v - 8'd100;
    end else begin
      r.hund = 2'd0;
      rem    = v;
    end
    r.tens = 4'd0;
    for (int j = 1; j < 10; j++) begin
      if (rem >= 8'(10 * j)) r.tens = 4'(j);
    end
    t8      = {4'b0000, r.tens};
    r.units = 4'(rem - (t8 << 3) - (t8 << 1));
    return r;
  endfunction

endpackage

/* design/ipat_if.sv */
interface ipat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  family;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [15:0] port_network;

  modport source(output valid, family, address_high, address_low, port_network,
                 input ready);
  modport sink(input valid, family, address_high, address_low, port_network,
               output ready);
endinterface

interface ipat_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  text_char;
  logic        is_last;
  logic        failed;
  logic [15:0] port_host;
  logic        family_out;

  modport source(output valid, text_char, is_last, failed, port_host, family_out,
                 input ready);
  modport sink(input valid, text_char, is_last, failed, port_host, family_out,
               output ready);
endinterface

/* design/ip_address_to_text.sv */
// Address-to-text formatter. Each input item (family, 128-bit address, port in
// network order) becomes a string of ASCII characters, one per output item:
// dotted decimal for IPv4, compressed lower-case hex groups for IPv6 with the
// first longest run of two or more zero groups written as "::". The final
// character carries is_last; every character carries the byte-swapped port and
// the family. An unsupported family, or text plus terminator longer than
// text_capacity (reset 64), gives one item with failed and is_last set and all
// other fields zero. Items are taken one at a time: ready is high only between
// items. A single character generator, stepping one slot per cycle (in the emit
// pass only while the output register can be loaded), is walked twice: once to
// count the text length, once to emit, with a check step between the passes.
// An IPv4 octet has hundreds, tens and units slots and, but for the last, a dot
// slot; an IPv6 group has a colon slot and four nibble slots, and a compressed
// zero run is skipped. An IPv6 item first runs a zero-run search over its eight
// groups; an unsupported family goes straight to the check step. The output
// register lets the next item be accepted while the last character still waits to be taken.
module ip_address_to_text
  import ipat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  ipat_in_if.sink             in_i,
  ipat_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CapW-1:0]     cfg_wdata_i
);

  state_e state_q, state_d;

  // Item held for the whole walk.
  logic [1:0]       fam_q, fam_d;
  logic [127:0]     addr_q, addr_d;
  logic [15:0]      port_q, port_d;
  logic [CapW-1:0]  cap_q, cap_d;

  // Zero-run search.
  logic [2:0]       zi_q, zi_d;
  logic [3:0]       zcur_q, zcur_d;
  logic [3:0]       zbl_q, zbl_d;
  logic [2:0]       zbs_q, zbs_d;

  // Generator cursor: group/octet index, slot within it, leading-zero flag.
  logic [2:0]       gi_q, gi_d;
  logic [2:0]       gp_q, gp_d;
  logic             started_q, started_d;
  logic [LenW-1:0]  len_q, len_d;

  // Output register.
  logic             ov_q, ov_d;
  logic [CharW-1:0] och_q, och_d;
  logic             olast_q, olast_d;
  logic             ofail_q, ofail_d;
  logic [15:0]      oport_q, oport_d;
  logic             ofam_q, ofam_d;

  logic             in_acc;
  logic             can_load;
  logic             bad;

  logic [2:0]       grp_idx;
  logic [15:0]      grp;
  logic [7:0]       octet;
  dec_t             dec;
  logic [1:0]       nib_idx;
  logic [3:0]       nib;
  logic             run_ok;
  logic [3:0]       run_end;
  logic [3:0]       zcur_inc;

  // Generator step results.
  logic             g_emit;
  logic [CharW-1:0] g_ch;
  logic             g_fin;
  logic [2:0]       g_gi;
  logic [2:0]       g_gp;
  logic             g_started;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign can_load   = !ov_q || out_o.ready;

  assign out_o.valid      = ov_q;
  assign out_o.text_char  = och_q;
  assign out_o.is_last    = olast_q;
  assign out_o.failed     = ofail_q;
  assign out_o.port_host  = oport_q;
  assign out_o.family_out = ofam_q;

  // Group select shared by the zero-run search and the generator.
  assign grp_idx = (state_q == StZrun) ? zi_q : gi_q;
  assign grp     = addr_q[{3'd7 - grp_idx, 4'd0} +: 16];
  assign octet   = addr_q[{2'd3 - gi_q[1:0], 3'd0} +: 8];
  assign dec     = byte_to_dec(octet);
  assign nib_idx = 2'(3'd4 - gp_q);
  assign nib     = grp[{nib_idx, 2'b00} +: 4];

  assign run_ok   = (zbl_q >= 4'd2);
  assign run_end  = {1'b0, zbs_q} + zbl_q;
  assign zcur_inc = zcur_q + 4'd1;

  assign bad = fam_q[1] || (({1'b0, len_q} + 7'd1) > cap_q);

  // One slot of the character generator.
  always_comb begin
    g_emit    = 1'b0;
    g_ch      = ChNull;
    g_fin     = 1'b0;
    g_gi      = gi_q;
    g_gp      = gp_q + 3'd1;
    g_started = started_q;
    if (fam_q == FamIpv4) begin
      case (gp_q)
        3'd0: begin
          g_emit = (dec.hund != 2'd0);
          g_ch   = ChZero + {5'b00000, dec.hund};
        end
        3'd1: begin
          g_emit = (octet >= 8'd10);
          g_ch   = ChZero + {3'b000, dec.tens};
        end
        3'd2: begin
          g_emit = 1'b1;
          g_ch   = ChZero + {3'b000, dec.units};
          g_fin  = (gi_q == 3'd3);
        end
        3'd3: begin
          // separator after every octet but the last
          g_emit = 1'b1;
          g_ch   = ChDot;
          g_gi   = gi_q + 3'd1;
          g_gp   = 3'd0;
        end
        default: begin
          g_gp = 3'd0;
        end
      endcase
    end else begin
      case (gp_q)
        3'd0: begin
          g_started = 1'b0;
          g_gp      = 3'd1;
          if (run_ok && gi_q == zbs_q) begin
            g_emit = 1'b1;
            g_ch   = ChColon;
            g_gp   = 3'd5;
          end else if (gi_q != 3'd0 && !(run_ok && {1'b0, gi_q} == run_end)) begin
            g_emit = 1'b1;
            g_ch   = ChColon;
          end
        end
        3'd1, 3'd2, 3'd3, 3'd4: begin
          // drop leading zeros, keep the last nibble always
          g_emit = (nib != 4'd0) || started_q || (gp_q == 3'd4);
          g_ch   = hex_char(nib);
          if (g_emit) g_started = 1'b1;
          if (gp_q == 3'd4) begin
            g_gi  = gi_q + 3'd1;
            g_gp  = 3'd0;
            g_fin = (gi_q == 3'd7);
          end
        end
        3'd5: begin
          // second colon of the compressed run, then skip over it
          g_emit = 1'b1;
          g_ch   = ChColon;
          g_gi   = run_end[2:0];
          g_gp   = 3'd1;
          g_fin  = run_end[3];
        end
        default: begin
          g_gp = 3'd0;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_i.family[1]) begin
            state_d = StCheck;
          end else if (in_i.family == FamIpv6) begin
            state_d = StZrun;
          end else begin
            state_d = StScan;
          end
        end
      end
      StZrun: begin
        if (zi_q == 3'd7) state_d = StScan;
      end
      StScan: begin
        if (g_fin) state_d = StCheck;
      end
      StCheck: begin
        if (!bad) begin
          state_d = StEmit;
        end else if (can_load) begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (can_load && g_fin) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    fam_d     = fam_q;
    addr_d    = addr_q;
    port_d    = port_q;
    cap_d     = cfg_we_i ? cfg_wdata_i : cap_q;
    zi_d      = zi_q;
    zcur_d    = zcur_q;
    zbl_d     = zbl_q;
    zbs_d     = zbs_q;
    gi_d      = gi_q;
    gp_d      = gp_q;
    started_d = started_q;
    len_d     = len_q;
    ov_d      = ov_q && !out_o.ready;
    och_d     = och_q;
    olast_d   = olast_q;
    ofail_d   = ofail_q;
    oport_d   = oport_q;
    ofam_d    = ofam_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          fam_d     = in_i.family;
          addr_d    = {in_i.address_high, in_i.address_low};
          port_d    = in_i.port_network;
          zi_d      = 3'd0;
          zcur_d    = 4'd0;
          zbl_d     = 4'd0;
          zbs_d     = 3'd0;
          gi_d      = 3'd0;
          gp_d      = 3'd0;
          started_d = 1'b0;
          len_d     = '0;
        end
      end
      StZrun: begin
        // track the first longest run of zero groups
        zi_d = zi_q + 3'd1;
        if (grp == 16'h0000) begin
          zcur_d = zcur_inc;
          if (zcur_inc > zbl_q) begin
            zbl_d = zcur_inc;
            zbs_d = zi_q - 3'(zcur_inc) + 3'd1;
          end
        end else begin
          zcur_d = 4'd0;
        end
      end
      StScan: begin
        gi_d      = g_gi;
        gp_d      = g_gp;
        started_d = g_started;
        if (g_emit) len_d = len_q + LenW'(1);
      end
      StCheck: begin
        gi_d      = 3'd0;
        gp_d      = 3'd0;
        started_d = 1'b0;
        if (bad && can_load) begin
          ov_d    = 1'b1;
          och_d   = ChNull;
          olast_d = 1'b1;
          ofail_d = 1'b1;
          oport_d = 16'h0000;
          ofam_d  = 1'b0;
        end
      end
      StEmit: begin
        if (can_load) begin
          gi_d      = g_gi;
          gp_d      = g_gp;
          started_d = g_started;
          if (g_emit) begin
            ov_d    = 1'b1;
            och_d   = g_ch;
            olast_d = g_fin;
            ofail_d = 1'b0;
            oport_d = {port_q[7:0], port_q[15:8]};
            ofam_d  = fam_q[0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q   <= CapReset;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cap_q   <= cap_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fam_q     <= fam_d;
    addr_q    <= addr_d;
    port_q    <= port_d;
    zi_q      <= zi_d;
    zcur_q    <= zcur_d;
    zbl_q     <= zbl_d;
    zbs_q     <= zbs_d;
    gi_q      <= gi_d;
    gp_q      <= gp_d;
    started_q <= started_d;
    len_q     <= len_d;
    och_q     <= och_d;
    olast_q   <= olast_d;
    ofail_q   <= ofail_d;
    oport_q   <= oport_d;
    ofam_q    <= ofam_d;
  end

endmodule

/* design/ipat_checker.sv */
module ipat_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] text_char_i,
  input logic       is_last_i,
  input logic       failed_i,
  input logic [15:0] port_host_i
);

  // An error item is always the only and last one.
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && failed_i |-> is_last_i)
    else $error("error item without is_last");

  // An error item carries no character and no port.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && failed_i |-> text_char_i == 7'd0 && port_host_i == 16'd0)
    else $error("error item with payload");

  // Text characters are never null.
  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !failed_i |-> text_char_i != 7'd0)
    else $error("null character in text");

  // Busy after taking an item.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken back to back");

  // Hold a stalled output item.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(text_char_i))
    else $error("stalled output item changed");

endmodule

bind ip_address_to_text ipat_checker u_ipat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .text_char_i (out_o.text_char),
  .is_last_i   (out_o.is_last),
  .failed_i    (out_o.failed),
  .port_host_i (out_o.port_host)
);
